@@ hw/rtl/pss_pkg.sv @@
package pss_pkg;

  localparam int NREGS = 4;
  localparam int IMP_MULT = 10;
  localparam logic [5:0] EMPTY_IMP = 6'd63;
  localparam logic [4:0] REG_RESET [NREGS] = '{5'd7, 5'd9, 5'd4, 5'd12};

  localparam logic [1:0] ACT_QUERY   = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_DEALLOC = 2'd2;
  localparam logic [1:0] ACT_SCHED   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  user;
    logic [1:0]  level;
    logic [1:0]  precedence;
    logic [15:0] allocated_mask;
  } req_t;

  typedef struct packed {
    logic [4:0] count;
    logic       granted;
    logic [3:0] granted_user;
    logic [1:0] granted_level;
  } rsp_t;

  typedef struct packed {
    logic [3:0] owner;
    logic [1:0] precedence;
    logic [3:0] entry_number;
    logic [5:0] importance;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LCAP,
    ST_SEL,
    ST_RES,
    ST_DRD,
    ST_DCHK,
    ST_SLVL,
    ST_SCHK,
    ST_FIN
  } state_t;

  function automatic logic [5:0] entry_imp(logic [1:0] p, int k);
    int v;
    v = (k == 0) ? int'(p) : IMP_MULT * int'(p) + k;
    return (v > int'(EMPTY_IMP)) ? EMPTY_IMP : 6'(v);
  endfunction

endpackage

@@ hw/rtl/priority_slot_scheduler_top.sv @@
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_stall   | pss_pkg::req_t
// rsp     | out       | rsp_valid / rsp_stall   | pss_pkg::rsp_t
// cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item at a time; the slot memory has one read and one write port.
// Query/allocate: capture the n active slots of the level, then up to n passes that
// scan them for the best one and resolve it. Deallocate: check all SLOTS slots of the
// level. Schedule: check slots level by level until a grant or two full passes end.
// Reset is synchronous; slot valid bits reset in flops, so no clearing pass. A stalled
// result holds; the next request is taken once the block is back in idle.
module priority_slot_scheduler_top #(
  parameter int LEVELS = 4,
  parameter int SLOTS  = 16,
  parameter int USERS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pss_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pss_pkg::rsp_t   rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [4:0]      cfg_data
);
  import pss_pkg::*;

  localparam int NSLOT = LEVELS * SLOTS;
  localparam int AW    = $clog2(NSLOT);
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int LCW   = $clog2(LEVELS + 1);
  localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  state_t state, state_next;

  logic [4:0]       slots_reg [NREGS];
  logic [NSLOT-1:0] valid_bits;
  slot_t            mem [NSLOT];
  slot_t            mem_q;
  logic             vld_q;
  logic [CW-1:0]    cursor [LEVELS];

  req_t             cur;
  logic [CW-1:0]    n, idx, kk, cnt;
  logic [IW-1:0]    best;
  logic             have;
  logic [5:0]       best_imp;
  logic [5:0]       loc_imp [SLOTS];
  logic [3:0]       loc_owner [SLOTS];
  logic [SLOTS-1:0] loc_valid, used;
  logic             granted;
  logic [3:0]       g_user;
  logic [1:0]       g_level;
  logic             sch_pass;
  logic [LCW-1:0]   sch_l;
  logic [LEVELS-1:0] nonempty;

  logic [CW-1:0]    lvl_n [LEVELS];
  logic             accept, bad, hit, cand, sch_hit, lvl_end, fin_go;
  logic [CW-1:0]    req_n, sch_n, cur_c;
  logic [5:0]       imp_k;
  logic [IW-1:0]    j;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             mem_we, wr_valid;
  slot_t            wr_data;

  function automatic logic [AW-1:0] addr_of(int l, int i);
    return AW'(l * SLOTS + i);
  endfunction

  always_comb begin
    int r;
    for (int l = 0; l < LEVELS; l++) begin
      r = (l < NREGS) ? int'(slots_reg[l % NREGS]) : SLOTS;
      lvl_n[l] = (r > SLOTS) ? CW'(SLOTS) : CW'(r);
    end
  end

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign bad       = (int'(req.level) >= LEVELS) || (int'(req.user) >= USERS);
  assign req_n     = lvl_n[LIW'(req.level)];
  assign sch_n     = lvl_n[sch_l[LIW-1:0]];
  assign cur_c     = cursor[sch_l[LIW-1:0]];
  assign lvl_end   = (int'(sch_l) == LEVELS);
  assign imp_k     = entry_imp(cur.precedence, int'(kk));
  assign hit       = (imp_k >= loc_imp[best]);
  assign j         = idx[IW-1:0];
  assign cand      = !used[j] && (!have || (loc_imp[j] > best_imp));
  assign sch_hit   = vld_q && cur.allocated_mask[mem_q.owner];
  assign fin_go    = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == ACT_SCHED) begin
            state_next = ST_SLVL;
          end else if (bad) begin
            state_next = ST_FIN;
          end else if (req.action == ACT_DEALLOC) begin
            state_next = ST_DRD;
          end else if (req_n == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_LRD;
          end
        end
      end
      ST_LRD:  state_next = ST_LCAP;
      ST_LCAP: state_next = (idx + 1'b1 == n) ? ST_SEL : ST_LRD;
      ST_SEL:  state_next = (idx + 1'b1 == n) ? ST_RES : ST_SEL;
      ST_RES:  state_next = (hit || (kk + 1'b1 == n)) ? ST_FIN : ST_SEL;
      ST_DRD:  state_next = ST_DCHK;
      ST_DCHK: state_next = (int'(idx) == SLOTS - 1) ? ST_FIN : ST_DRD;
      ST_SLVL: begin
        if (lvl_end) begin
          if (sch_pass) begin
            state_next = ST_FIN;
          end
        end else if (nonempty[sch_l[LIW-1:0]] && (cur_c < sch_n)) begin
          state_next = ST_SCHK;
        end
      end
      ST_SCHK: state_next = sch_hit ? ST_FIN : ST_SLVL;
      ST_FIN:  state_next = fin_go ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = '0;
    mem_we   = 1'b0;
    wr_addr  = '0;
    wr_valid = 1'b0;
    wr_data  = '{owner: 4'd0, precedence: 2'd0, entry_number: 4'd0, importance: EMPTY_IMP};
    unique case (state)
      ST_LRD, ST_DRD: rd_addr = addr_of(int'(cur.level), int'(idx));
      ST_SLVL:        rd_addr = addr_of(int'(sch_l), int'(cur_c));
      ST_RES: begin
        if (cur.action == ACT_ALLOC && !hit) begin
          mem_we   = 1'b1;
          wr_valid = 1'b1;
          wr_addr  = addr_of(int'(cur.level), int'(best));
          wr_data  = '{owner: cur.user, precedence: cur.precedence,
                       entry_number: 4'(kk), importance: imp_k};
        end
      end
      ST_DCHK: begin
        if (vld_q && mem_q.owner == cur.user) begin
          mem_we  = 1'b1;
          wr_addr = addr_of(int'(cur.level), int'(idx));
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
    vld_q <= valid_bits[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      valid_bits <= '0;
      for (int r = 0; r < NREGS; r++) begin
        slots_reg[r] <= REG_RESET[r];
      end
      for (int l = 0; l < LEVELS; l++) begin
        cursor[l] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        slots_reg[cfg_index] <= cfg_data;
      end
      if (mem_we) begin
        valid_bits[wr_addr] <= wr_valid;
      end
      if (state == ST_FIN && fin_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_SLVL && !lvl_end && nonempty[sch_l[LIW-1:0]]) begin
        if (cur_c >= sch_n) begin
          cursor[sch_l[LIW-1:0]] <= '0;
        end else begin
          cursor[sch_l[LIW-1:0]] <= cur_c + 1'b1;
        end
      end
    end

    unique case (state)
      ST_IDLE: begin
        cur      <= req;
        n        <= req_n;
        idx      <= '0;
        kk       <= '0;
        cnt      <= '0;
        have     <= 1'b0;
        used     <= '0;
        granted  <= 1'b0;
        g_user   <= '0;
        g_level  <= '0;
        sch_pass <= 1'b0;
        sch_l    <= '0;
        for (int l = 0; l < LEVELS; l++) begin
          nonempty[l] <= valid_bits[l * SLOTS];
        end
      end
      ST_LCAP: begin
        loc_imp[j]   <= vld_q ? mem_q.importance : EMPTY_IMP;
        loc_owner[j] <= mem_q.owner;
        loc_valid[j] <= vld_q;
        idx          <= (idx + 1'b1 == n) ? '0 : idx + 1'b1;
      end
      ST_SEL: begin
        if (cand) begin
          best     <= j;
          best_imp <= loc_imp[j];
          have     <= 1'b1;
        end
        idx <= (idx + 1'b1 == n) ? '0 : idx + 1'b1;
      end
      ST_RES: begin
        if (!hit) begin
          used[best] <= 1'b1;
          have       <= 1'b0;
          kk         <= kk + 1'b1;
          if (cur.action == ACT_ALLOC || !loc_valid[best] ||
              loc_owner[best] != cur.user) begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      ST_DCHK: begin
        if (vld_q && mem_q.owner == cur.user) begin
          cnt <= cnt + 1'b1;
        end
        idx <= idx + 1'b1;
      end
      ST_SLVL: begin
        if (lvl_end) begin
          sch_pass <= 1'b1;
          sch_l    <= '0;
        end else if (!nonempty[sch_l[LIW-1:0]] || cur_c >= sch_n) begin
          sch_l <= sch_l + 1'b1;
        end
      end
      ST_SCHK: begin
        if (sch_hit) begin
          granted <= 1'b1;
          g_user  <= mem_q.owner;
          g_level <= 2'(sch_l);
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          rsp <= '{count: 5'(cnt), granted: granted, granted_user: g_user,
                   granted_level: g_level};
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != ST_IDLE))
    else $error("accepted request did not start work");

  a_grant_no_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.granted) |-> (rsp.count == 5'd0))
    else $error("grant carries a nonzero count");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_RES || state == ST_DCHK))
    else $error("slot write outside update states");

  a_fin_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && fin_go) |=> rsp_valid)
    else $error("finished item did not reach the output");

endmodule
